FILE: rtl/core/tce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console engine package
// Shared geometry constants, character codes, command codes, the datapath
// operation set, and the control and status types between controller and
// datapath.
// ----------------------------------------------------------------------------
package tce_pkg;

	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int MEMORY_CELLS = 8192;

	localparam int CELL_W       = $clog2(MEMORY_CELLS);
	localparam int COL_W        = $clog2(COLUMNS + 1);
	localparam int ROW_W        = $clog2(ROWS);
	localparam int CNT_W        = $clog2(MEMORY_CELLS + 1);
	localparam int SCREEN_CELLS = ROWS * COLUMNS;
	localparam int COPY_CELLS   = (SCREEN_CELLS < MEMORY_CELLS) ? SCREEN_CELLS : MEMORY_CELLS;
	localparam int SCREEN_MOD   = SCREEN_CELLS % MEMORY_CELLS;
	localparam int SCROLL_SPAN  = SCREEN_CELLS + COLUMNS;

	localparam logic [15:0] BLANK_CELL = 16'h0720;
	localparam logic [7:0]  ATTR_RESET = 8'h07;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_HT  = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_DEL = 8'h7F;

	typedef enum logic [2:0] {
		CC_IGNORE,
		CC_BS,
		CC_LF,
		CC_FF,
		CC_CR,
		CC_DEL,
		CC_PRINT
	} char_class_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_LINE,
		ST_COPY,
		ST_BLANK,
		ST_TAIL,
		ST_CLEAR,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_PUT,
		OP_BS,
		OP_DEL,
		OP_CR,
		OP_WRAP,
		OP_LINE,
		OP_COPY_INIT,
		OP_COPY,
		OP_BLANK_INIT,
		OP_BLANK,
		OP_SWEEP_INIT,
		OP_SWEEP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   latch;
		logic   rd_port;
		logic   fin;
		logic   fin_write;
		logic   fin_read;
	} dp_cmd_t;

	typedef struct packed {
		logic col_zero;
		logic col_full;
		logic row_last;
		logic need_copy;
		logic copy_end;
		logic blank_end;
		logic sweep_end;
	} dp_stat_t;

	function automatic char_class_t classify(input logic [7:0] ch);
		char_class_t cls;
		case (ch) inside
			CH_NUL, CH_BEL, CH_HT, CH_VT: cls = CC_IGNORE;
			CH_BS:                        cls = CC_BS;
			CH_LF:                        cls = CC_LF;
			CH_FF:                        cls = CC_FF;
			CH_CR:                        cls = CC_CR;
			CH_DEL:                       cls = CC_DEL;
			default:                      cls = CC_PRINT;
		endcase
		return cls;
	endfunction

	// Both operands are already below MEMORY_CELLS.
	function automatic logic [CELL_W-1:0] cell_add(input logic [CELL_W-1:0] a,
		input logic [CELL_W-1:0] b);
		logic [CELL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (CELL_W+1)'(MEMORY_CELLS)) begin
			s = s - (CELL_W+1)'(MEMORY_CELLS);
		end
		return s[CELL_W-1:0];
	endfunction

	function automatic logic [CELL_W-1:0] cell_sub(input logic [CELL_W-1:0] a,
		input logic [CELL_W-1:0] b);
		logic [CELL_W:0] s;
		s = {1'b0, a} - {1'b0, b};
		if (s[CELL_W]) begin
			s = s + (CELL_W+1)'(MEMORY_CELLS);
		end
		return s[CELL_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tce_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console controller
// Sequences each command into datapath operations: single-cell edits, line
// moves, copy-back and row blanking walks, the memory sweep, and the output
// register load.
// ----------------------------------------------------------------------------
module tce_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	input  wire logic [1:0]        command,
	input  wire logic [7:0]        char_byte,
	output logic                   cmd_stall,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output tce_pkg::dp_cmd_t       dp_cmd,
	input  wire tce_pkg::dp_stat_t dp_stat
);

	tce_pkg::ctrl_state_t state_q, state_d;
	tce_pkg::char_class_t cls_q;
	logic [1:0]           cmd_q;
	logic                 rsp_valid_q;
	logic                 out_free;
	logic                 can_accept;
	logic                 accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tce_pkg::ST_INIT;
			cls_q       <= tce_pkg::CC_IGNORE;
			cmd_q       <= tce_pkg::CMD_WRITE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cls_q <= tce_pkg::classify(char_byte);
				cmd_q <= command;
			end
			if (dp_cmd.fin) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		out_free   = !rsp_valid_q || !rsp_stall;
		can_accept = (state_q == tce_pkg::ST_IDLE) ||
			((state_q == tce_pkg::ST_DONE) && out_free);
		accept     = can_accept && cmd_valid;

		state_d           = state_q;
		dp_cmd.op         = tce_pkg::OP_NONE;
		dp_cmd.latch      = accept;
		dp_cmd.rd_port    = 1'b0;
		dp_cmd.fin        = 1'b0;
		dp_cmd.fin_write  = (cmd_q == tce_pkg::CMD_WRITE);
		dp_cmd.fin_read   = (cmd_q == tce_pkg::CMD_READ);

		unique case (state_q)
			tce_pkg::ST_INIT: begin
				dp_cmd.op = tce_pkg::OP_SWEEP;
				if (dp_stat.sweep_end) begin
					state_d = tce_pkg::ST_IDLE;
				end
			end
			tce_pkg::ST_IDLE: begin
			end
			tce_pkg::ST_EXEC: begin
				state_d = tce_pkg::ST_DONE;
				case (cls_q) inside
					tce_pkg::CC_BS: begin
						if (!dp_stat.col_zero) begin
							dp_cmd.op = tce_pkg::OP_BS;
						end
					end
					tce_pkg::CC_DEL: dp_cmd.op = tce_pkg::OP_DEL;
					tce_pkg::CC_CR:  dp_cmd.op = tce_pkg::OP_CR;
					tce_pkg::CC_LF, tce_pkg::CC_FF: state_d = tce_pkg::ST_LINE;
					tce_pkg::CC_PRINT: begin
						if (dp_stat.col_full) begin
							dp_cmd.op = tce_pkg::OP_WRAP;
							state_d   = tce_pkg::ST_LINE;
						end else begin
							dp_cmd.op = tce_pkg::OP_PUT;
						end
					end
					default: begin
					end
				endcase
			end
			tce_pkg::ST_LINE: begin
				if (!dp_stat.row_last) begin
					dp_cmd.op = tce_pkg::OP_LINE;
					state_d   = tce_pkg::ST_TAIL;
				end else if (dp_stat.need_copy) begin
					dp_cmd.op = tce_pkg::OP_COPY_INIT;
					state_d   = tce_pkg::ST_COPY;
				end else begin
					dp_cmd.op = tce_pkg::OP_BLANK_INIT;
					state_d   = tce_pkg::ST_BLANK;
				end
			end
			tce_pkg::ST_COPY: begin
				dp_cmd.op = tce_pkg::OP_COPY;
				if (dp_stat.copy_end) begin
					state_d = tce_pkg::ST_BLANK;
				end
			end
			tce_pkg::ST_BLANK: begin
				dp_cmd.op = tce_pkg::OP_BLANK;
				if (dp_stat.blank_end) begin
					state_d = tce_pkg::ST_TAIL;
				end
			end
			tce_pkg::ST_TAIL: begin
				state_d = tce_pkg::ST_DONE;
				case (cls_q)
					tce_pkg::CC_PRINT: dp_cmd.op = tce_pkg::OP_PUT;
					tce_pkg::CC_LF:    dp_cmd.op = tce_pkg::OP_CR;
					default: begin
					end
				endcase
			end
			tce_pkg::ST_CLEAR: begin
				dp_cmd.op = tce_pkg::OP_SWEEP;
				if (dp_stat.sweep_end) begin
					state_d = tce_pkg::ST_DONE;
				end
			end
			tce_pkg::ST_DONE: begin
				if (out_free) begin
					dp_cmd.fin = 1'b1;
					state_d    = tce_pkg::ST_IDLE;
				end
			end
			default: state_d = tce_pkg::ST_INIT;
		endcase

		// A new command may be taken in the same cycle as the result load.
		if (accept) begin
			unique case (command)
				tce_pkg::CMD_WRITE: state_d = tce_pkg::ST_EXEC;
				tce_pkg::CMD_CLEAR: begin
					dp_cmd.op = tce_pkg::OP_SWEEP_INIT;
					state_d   = tce_pkg::ST_CLEAR;
				end
				tce_pkg::CMD_READ: begin
					dp_cmd.rd_port = 1'b1;
					state_d        = tce_pkg::ST_DONE;
				end
				default: state_d = tce_pkg::ST_DONE;
			endcase
		end

		cmd_stall = !can_accept;
		rsp_valid = rsp_valid_q;
	end

endmodule
`default_nettype wire

FILE: rtl/core/tce_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console datapath
// Video memory, cursor and screen registers, the walk counter and addresses
// used by the copy-back, row blanking and sweep, and the result register.
// ----------------------------------------------------------------------------
module tce_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tce_pkg::dp_cmd_t             dp_cmd,
	output tce_pkg::dp_stat_t                 dp_stat,
	input  wire logic [7:0]                   char_byte,
	input  wire logic                         last_of_write,
	input  wire logic [tce_pkg::CELL_W-1:0]   cell_address,
	input  wire logic                         attr_we,
	input  wire logic [7:0]                   attr_wdata,
	output logic [tce_pkg::CELL_W-1:0]        screen_start,
	output logic [tce_pkg::CELL_W-1:0]        cursor_cell,
	output logic [15:0]                       read_data
);

	localparam int CW = tce_pkg::CELL_W;

	logic [15:0]                  vram_q [tce_pkg::MEMORY_CELLS];
	logic [15:0]                  rd_q;
	logic [7:0]                   attr_q;
	logic [CW-1:0]                base_q, base_d;
	logic [CW-1:0]                wcell_q, wcell_d;
	logic [tce_pkg::COL_W-1:0]    col_q, col_d;
	logic [tce_pkg::ROW_W-1:0]    row_q, row_d;
	logic [CW-1:0]                shown_q, shown_d;
	logic [tce_pkg::CNT_W-1:0]    cnt_q, cnt_d;
	logic [CW-1:0]                src_q, src_d;
	logic [CW-1:0]                dst_q, dst_d;
	logic [7:0]                   char_q;
	logic                         last_q;
	logic [CW-1:0]                out_start_q, out_cursor_q;
	logic [15:0]                  out_data_q;
	logic                         we, re;
	logic [CW-1:0]                wa, ra;
	logic [15:0]                  wd;

	always_comb begin
		dp_stat.col_zero  = (col_q == '0);
		dp_stat.col_full  = (col_q >= tce_pkg::COL_W'(tce_pkg::COLUMNS));
		dp_stat.row_last  = (row_q >= tce_pkg::ROW_W'(tce_pkg::ROWS - 1));
		dp_stat.need_copy = (32'(base_q) + 32'(tce_pkg::SCROLL_SPAN)) >=
			32'(tce_pkg::MEMORY_CELLS);
		dp_stat.copy_end  = (cnt_q == tce_pkg::CNT_W'(tce_pkg::COPY_CELLS));
		dp_stat.blank_end = (cnt_q == tce_pkg::CNT_W'(tce_pkg::COLUMNS - 1));
		dp_stat.sweep_end = (cnt_q == tce_pkg::CNT_W'(tce_pkg::MEMORY_CELLS - 1));
	end

	always_comb begin
		base_d  = base_q;
		wcell_d = wcell_q;
		col_d   = col_q;
		row_d   = row_q;
		cnt_d   = cnt_q;
		src_d   = src_q;
		dst_d   = dst_q;
		we      = 1'b0;
		wa      = wcell_q;
		wd      = tce_pkg::BLANK_CELL;
		re      = dp_cmd.rd_port;
		ra      = cell_address;

		unique case (dp_cmd.op)
			tce_pkg::OP_NONE: begin
			end
			tce_pkg::OP_PUT: begin
				we      = 1'b1;
				wd      = {attr_q, char_q};
				wcell_d = tce_pkg::cell_add(wcell_q, CW'(1));
				col_d   = col_q + tce_pkg::COL_W'(1);
			end
			tce_pkg::OP_BS: begin
				we      = 1'b1;
				wa      = tce_pkg::cell_sub(wcell_q, CW'(1));
				wcell_d = wa;
				col_d   = col_q - tce_pkg::COL_W'(1);
			end
			tce_pkg::OP_DEL: we = 1'b1;
			tce_pkg::OP_CR: begin
				wcell_d = tce_pkg::cell_sub(wcell_q, CW'(col_q));
				col_d   = '0;
			end
			tce_pkg::OP_WRAP: begin
				wcell_d = tce_pkg::cell_sub(wcell_q, CW'(tce_pkg::COLUMNS));
				col_d   = col_q - tce_pkg::COL_W'(tce_pkg::COLUMNS);
			end
			tce_pkg::OP_LINE: begin
				wcell_d = tce_pkg::cell_add(wcell_q, CW'(tce_pkg::COLUMNS));
				row_d   = row_q + tce_pkg::ROW_W'(1);
			end
			tce_pkg::OP_COPY_INIT: begin
				cnt_d = '0;
				src_d = base_q;
				dst_d = '0;
			end
			tce_pkg::OP_COPY: begin
				// Reads run one cell ahead of the writes they feed.
				if (!dp_stat.copy_end) begin
					re    = 1'b1;
					ra    = src_q;
					src_d = tce_pkg::cell_add(src_q, CW'(1));
					cnt_d = cnt_q + tce_pkg::CNT_W'(1);
				end
				if (cnt_q != '0) begin
					we    = 1'b1;
					wa    = dst_q;
					wd    = rd_q;
					dst_d = tce_pkg::cell_add(dst_q, CW'(1));
				end
				if (dp_stat.copy_end) begin
					wcell_d = tce_pkg::cell_sub(wcell_q, base_q);
					base_d  = '0;
					cnt_d   = '0;
					dst_d   = CW'(tce_pkg::SCREEN_MOD);
				end
			end
			tce_pkg::OP_BLANK_INIT: begin
				cnt_d = '0;
				dst_d = tce_pkg::cell_add(base_q, CW'(tce_pkg::SCREEN_MOD));
			end
			tce_pkg::OP_BLANK: begin
				we    = 1'b1;
				wa    = dst_q;
				dst_d = tce_pkg::cell_add(dst_q, CW'(1));
				cnt_d = cnt_q + tce_pkg::CNT_W'(1);
				if (dp_stat.blank_end) begin
					base_d  = tce_pkg::cell_add(base_q, CW'(tce_pkg::COLUMNS));
					wcell_d = tce_pkg::cell_add(wcell_q, CW'(tce_pkg::COLUMNS));
				end
			end
			tce_pkg::OP_SWEEP_INIT: cnt_d = '0;
			tce_pkg::OP_SWEEP: begin
				we    = 1'b1;
				wa    = cnt_q[CW-1:0];
				cnt_d = cnt_q + tce_pkg::CNT_W'(1);
				if (dp_stat.sweep_end) begin
					base_d  = '0;
					wcell_d = '0;
					col_d   = '0;
					row_d   = '0;
				end
			end
			default: begin
			end
		endcase

		shown_d = shown_q;
		if (dp_cmd.op == tce_pkg::OP_SWEEP && dp_stat.sweep_end) begin
			shown_d = '0;
		end else if (dp_cmd.fin && dp_cmd.fin_write && last_q) begin
			shown_d = wcell_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q  <= tce_pkg::ATTR_RESET;
			base_q  <= '0;
			wcell_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
			shown_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (attr_we) begin
				attr_q <= attr_wdata;
			end
			base_q  <= base_d;
			wcell_q <= wcell_d;
			col_q   <= col_d;
			row_q   <= row_d;
			shown_q <= shown_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		src_q <= src_d;
		dst_q <= dst_d;
		if (dp_cmd.latch) begin
			char_q <= char_byte;
			last_q <= last_of_write;
		end
		if (dp_cmd.fin) begin
			out_start_q  <= base_q;
			out_cursor_q <= shown_d;
			out_data_q   <= dp_cmd.fin_read ? rd_q : 16'h0000;
		end
	end

	// Video memory: one write and one registered read per cycle. A read of the
	// cell being written in the same cycle returns the new contents.
	always_ff @(posedge clk) begin
		if (we) begin
			vram_q[wa] <= wd;
		end
		if (re) begin
			rd_q <= (we && (wa == ra)) ? wd : vram_q[ra];
		end
	end

	assign screen_start = out_start_q;
	assign cursor_cell  = out_cursor_q;
	assign read_data    = out_data_q;

endmodule
`default_nettype wire

FILE: rtl/core/text_console_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console engine
// Owns the text video memory and drives it as a cursor terminal.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the cmd channel (cmd_valid/cmd_stall): write one byte,
// clear the console, or read one cell. Every command gives exactly one result
// transfer on the rsp channel (rsp_valid/rsp_stall) holding the screen start,
// the shown cursor and, for a read, the cell contents.
// A scroll also blanks the new row, and a copy-back first moves the screen to
// the start of memory; both walks go through the single video memory write
// port. A clear walks the whole memory. After reset the block blanks all
// MEMORY_CELLS (8192) cells, one cell per cycle, with cmd_stall high;
// attribute writes are taken throughout. The result sits in an output
// register: while the receiver stalls, one further command is taken and
// processed, then the block stalls until the waiting result is transferred.
// ----------------------------------------------------------------------------
module text_console_engine (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	output logic                            cmd_stall,
	input  wire logic [1:0]                 command,
	input  wire logic [7:0]                 char_byte,
	input  wire logic                       last_of_write,
	input  wire logic [tce_pkg::CELL_W-1:0] cell_address,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output logic [tce_pkg::CELL_W-1:0]      screen_start,
	output logic [tce_pkg::CELL_W-1:0]      cursor_cell,
	output logic [15:0]                     read_data,
	input  wire logic                       attr_we,
	input  wire logic [7:0]                 attr_wdata
);

	tce_pkg::dp_cmd_t  dp_cmd;
	tce_pkg::dp_stat_t dp_stat;

	tce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (command),
		.char_byte (char_byte),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	tce_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.dp_cmd        (dp_cmd),
		.dp_stat       (dp_stat),
		.char_byte     (char_byte),
		.last_of_write (last_of_write),
		.cell_address  (cell_address),
		.attr_we       (attr_we),
		.attr_wdata    (attr_wdata),
		.screen_start  (screen_start),
		.cursor_cell   (cursor_cell),
		.read_data     (read_data)
	);

	// No command is taken while the memory sweep is running.
	a_sweep_blocks_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.op == tce_pkg::OP_SWEEP) |-> cmd_stall)
		else $error("command taken during memory sweep");

	// A result is only loaded when the output register is free or draining.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.fin |-> !(rsp_valid && rsp_stall))
		else $error("result overwritten while stalled");

	// Copy-back starts only on a scroll that would overflow the memory.
	a_copy_on_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.op == tce_pkg::OP_COPY_INIT) |-> (dp_stat.row_last && dp_stat.need_copy))
		else $error("copy-back started without overflow");

	// The walk that follows a copy-back is always the row blanking.
	a_copy_then_blank: assert property (@(posedge clk) disable iff (!arst_n)
		((dp_cmd.op == tce_pkg::OP_COPY) && dp_stat.copy_end) |=>
		(dp_cmd.op == tce_pkg::OP_BLANK))
		else $error("copy-back not followed by row blanking");

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console engine testbench
// Drives write, clear, read and unused commands into the console engine. A
// cycle-level driver feeds them from a queue of pending commands, in bursts
// with random gaps. A monitor stalls the result channel in changing patterns,
// with a long hold-off now and then. An in-bench model of the video memory
// and cursor predicts every result, and the monitor checks each transfer
// field by field. Directed bytes come first, then random traffic rich in
// long lines, scroll bursts and reads, under several attribute settings.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CLK_HALF     = 10;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASE_ITEMS  = 94;
	localparam int HOLD_CYCLES  = 500;
	localparam int HOLD_SPACING = 150;

	typedef struct packed {
		logic [1:0]                 command;
		logic [7:0]                 ch;
		logic                       last;
		logic [tce_pkg::CELL_W-1:0] addr;
	} console_cmd_t;

	typedef struct packed {
		logic [tce_pkg::CELL_W-1:0] screen_start;
		logic [tce_pkg::CELL_W-1:0] cursor_cell;
		logic [15:0]                read_data;
	} console_rsp_t;

	logic                       clk           = 1'b0;
	logic                       arst_n        = 1'b0;
	logic                       cmd_valid     = 1'b0;
	logic                       cmd_stall;
	logic [1:0]                 command       = tce_pkg::CMD_WRITE;
	logic [7:0]                 char_byte     = 8'h00;
	logic                       last_of_write = 1'b0;
	logic [tce_pkg::CELL_W-1:0] cell_address  = '0;
	logic                       rsp_valid;
	logic                       rsp_stall     = 1'b0;
	logic [tce_pkg::CELL_W-1:0] screen_start;
	logic [tce_pkg::CELL_W-1:0] cursor_cell;
	logic [15:0]                read_data;
	logic                       attr_we       = 1'b0;
	logic [7:0]                 attr_wdata    = 8'h00;

	// Predicted console state
	logic [15:0]                vmem [tce_pkg::MEMORY_CELLS];
	logic [tce_pkg::CELL_W-1:0] m_base;
	logic [tce_pkg::CELL_W-1:0] m_wcell;
	logic [tce_pkg::CELL_W-1:0] m_shown;
	int unsigned                m_col;
	int unsigned                m_row;
	logic [7:0]                 m_attr;

	console_cmd_t pending_cmds[$];
	console_rsp_t expected_rsps[$];

	int unsigned error_count    = 0;
	int unsigned accepted_count = 0;
	int unsigned burst_left     = 0;
	int unsigned gap_left       = 0;
	int unsigned stall_left     = 0;
	int unsigned stall_mode     = 0;
	int unsigned hold_left      = 0;
	int unsigned holds_done     = 0;
	int unsigned cycle_count    = 0;

	text_console_engine i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.command       (command),
		.char_byte     (char_byte),
		.last_of_write (last_of_write),
		.cell_address  (cell_address),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.screen_start  (screen_start),
		.cursor_cell   (cursor_cell),
		.read_data     (read_data),
		.attr_we       (attr_we),
		.attr_wdata    (attr_wdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Console model
	// ------------------------------------------------------------------
	function automatic logic [tce_pkg::CELL_W-1:0] cell_fwd(input int unsigned a,
		input int unsigned b);
		return tce_pkg::CELL_W'((a + b) % tce_pkg::MEMORY_CELLS);
	endfunction

	function automatic logic [tce_pkg::CELL_W-1:0] cell_back(input int unsigned a,
		input int unsigned b);
		return tce_pkg::CELL_W'((a % tce_pkg::MEMORY_CELLS + tce_pkg::MEMORY_CELLS -
			b % tce_pkg::MEMORY_CELLS) % tce_pkg::MEMORY_CELLS);
	endfunction

	task automatic blank_console();
		int unsigned i;
		for (i = 0; i < tce_pkg::MEMORY_CELLS; i++) begin
			vmem[i] = tce_pkg::BLANK_CELL;
		end
		m_base  = '0;
		m_wcell = '0;
		m_shown = '0;
		m_col   = 0;
		m_row   = 0;
	endtask

	task automatic line_down();
		int unsigned i;
		if (m_row + 1 < tce_pkg::ROWS) begin
			m_row++;
			m_wcell = cell_fwd(m_wcell, tce_pkg::COLUMNS);
		end else begin
			// Not enough room below the screen: move the visible page back to cell 0.
			if (!(int'(m_base) + tce_pkg::SCREEN_CELLS + tce_pkg::COLUMNS <
				tce_pkg::MEMORY_CELLS)) begin
				for (i = 0; i < tce_pkg::COPY_CELLS; i++) begin
					vmem[i] = vmem[cell_fwd(m_base, i)];
				end
				m_wcell = cell_back(m_wcell, m_base);
				m_base  = '0;
			end
			for (i = 0; i < tce_pkg::COLUMNS; i++) begin
				vmem[cell_fwd(m_base, tce_pkg::SCREEN_CELLS + i)] = tce_pkg::BLANK_CELL;
			end
			m_base  = cell_fwd(m_base, tce_pkg::COLUMNS);
			m_wcell = cell_fwd(m_wcell, tce_pkg::COLUMNS);
		end
	endtask

	task automatic carriage_return();
		m_wcell = cell_back(m_wcell, m_col);
		m_col   = 0;
	endtask

	task automatic put_char(input logic [7:0] ch);
		case (ch) inside
			tce_pkg::CH_NUL, tce_pkg::CH_BEL, tce_pkg::CH_HT, tce_pkg::CH_VT: begin
			end
			tce_pkg::CH_BS: begin
				if (m_col != 0) begin
					m_col--;
					m_wcell = cell_back(m_wcell, 1);
					vmem[m_wcell] = tce_pkg::BLANK_CELL;
				end
			end
			tce_pkg::CH_LF: begin
				line_down();
				carriage_return();
			end
			tce_pkg::CH_FF: begin
				line_down();
			end
			tce_pkg::CH_CR: begin
				carriage_return();
			end
			tce_pkg::CH_DEL: begin
				vmem[m_wcell] = tce_pkg::BLANK_CELL;
			end
			default: begin
				// A full line wraps before the glyph is stored.
				if (m_col >= tce_pkg::COLUMNS) begin
					m_col   = m_col - tce_pkg::COLUMNS;
					m_wcell = cell_back(m_wcell, tce_pkg::COLUMNS);
					line_down();
				end
				vmem[m_wcell] = {m_attr, ch};
				m_wcell = cell_fwd(m_wcell, 1);
				m_col++;
			end
		endcase
	endtask

	task automatic console_step(input console_cmd_t c, output console_rsp_t r);
		r.read_data = 16'h0000;
		case (c.command)
			tce_pkg::CMD_WRITE: begin
				put_char(c.ch);
				if (c.last) begin
					m_shown = m_wcell;
				end
			end
			tce_pkg::CMD_CLEAR: begin
				blank_console();
			end
			tce_pkg::CMD_READ: begin
				r.read_data = vmem[c.addr];
			end
			default: begin
			end
		endcase
		r.screen_start = m_base;
		r.cursor_cell  = m_shown;
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_cmd(input logic [1:0] cmd, input logic [7:0] ch, input logic last,
		input logic [tce_pkg::CELL_W-1:0] addr);
		console_cmd_t c;
		c.command = cmd;
		c.ch      = ch;
		c.last    = last;
		c.addr    = addr;
		pending_cmds.push_back(c);
	endtask

	task automatic add_write(input logic [7:0] ch, input logic last);
		add_cmd(tce_pkg::CMD_WRITE, ch, last, tce_pkg::CELL_W'($urandom));
	endtask

	task automatic add_read(input logic [tce_pkg::CELL_W-1:0] addr);
		add_cmd(tce_pkg::CMD_READ, 8'($urandom), 1'($urandom), addr);
	endtask

	function automatic logic [7:0] random_glyph();
		logic [7:0] b;
		b = 8'($urandom_range(8'h20, 8'hFF));
		if (b == tce_pkg::CH_DEL) begin
			b = 8'h7E;
		end
		return b;
	endfunction

	function automatic logic [7:0] random_control();
		logic [7:0] b;
		case ($urandom_range(0, 8))
			0: b = tce_pkg::CH_BS;
			1: b = tce_pkg::CH_LF;
			2: b = tce_pkg::CH_CR;
			3: b = tce_pkg::CH_FF;
			4: b = tce_pkg::CH_DEL;
			5: b = tce_pkg::CH_NUL;
			6: b = tce_pkg::CH_BEL;
			7: b = tce_pkg::CH_HT;
			default: b = tce_pkg::CH_VT;
		endcase
		return b;
	endfunction

	task automatic queue_random_traffic(input int unsigned count);
		int unsigned made;
		int unsigned n;
		int unsigned k;
		int unsigned r;
		int unsigned p;
		logic [1:0]  cmd;
		made = 0;
		while (made < count) begin
			// Each phase opens with a scroll burst so that the copy-back is reached.
			r = (made == 0) ? 40 : $urandom_range(0, 99);
			if (r < 30) begin
				n = $urandom_range(60, 130);
				if (n > count - made) begin
					n = count - made;
				end
				for (k = 0; k < n; k++) begin
					add_write(($urandom_range(0, 9) == 0) ? random_control() : random_glyph(),
						(k == n - 1) || ($urandom_range(0, 3) == 0));
				end
			end else if (r < 75) begin
				n = $urandom_range(30, 80);
				if (n > count - made) begin
					n = count - made;
				end
				for (k = 0; k < n; k++) begin
					p = $urandom_range(0, 9);
					add_write((p < 7) ? tce_pkg::CH_LF : (p < 8) ? tce_pkg::CH_FF :
						random_glyph(), (k == n - 1) || ($urandom_range(0, 2) == 0));
				end
			end else if (r < 86) begin
				n = $urandom_range(3, 12);
				if (n > count - made) begin
					n = count - made;
				end
				for (k = 0; k < n; k++) begin
					add_read(($urandom_range(0, 1) == 0) ?
						tce_pkg::CELL_W'($urandom_range(0, 2559)) :
						tce_pkg::CELL_W'($urandom));
				end
			end else if (r < 98) begin
				n = $urandom_range(5, 15);
				if (n > count - made) begin
					n = count - made;
				end
				for (k = 0; k < n; k++) begin
					cmd = 2'($urandom_range(0, 3));
					if (cmd == tce_pkg::CMD_CLEAR) begin
						cmd = CMD_UNUSED;
					end
					add_cmd(cmd, 8'($urandom), 1'($urandom), tce_pkg::CELL_W'($urandom));
				end
			end else begin
				n = 1;
				add_cmd(tce_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom),
					tce_pkg::CELL_W'($urandom));
			end
			made += n;
		end
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || cmd_valid || expected_rsps.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic write_text_attribute(input logic [7:0] value);
		@(posedge clk);
		attr_we    <= 1'b1;
		attr_wdata <= value;
		@(posedge clk);
		attr_we    <= 1'b0;
		m_attr = value;
	endtask

	// ------------------------------------------------------------------
	// Driver: presents pending commands in bursts and predicts each transfer
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		console_cmd_t nxt;
		console_cmd_t cur;
		console_rsp_t rsp;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				cur.command = command;
				cur.ch      = char_byte;
				cur.last    = last_of_write;
				cur.addr    = cell_address;
				console_step(cur, rsp);
				expected_rsps.push_back(rsp);
				accepted_count <= accepted_count + 1;
			end
			if (!cmd_valid || !cmd_stall) begin
				if (gap_left != 0) begin
					gap_left  <= gap_left - 1;
					cmd_valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					nxt = pending_cmds.pop_front();
					cmd_valid     <= 1'b1;
					command       <= nxt.command;
					char_byte     <= nxt.ch;
					last_of_write <= nxt.last;
					cell_address  <= nxt.addr;
					if (burst_left <= 1) begin
						if ($urandom_range(0, 3) == 0) begin
							burst_left <= $urandom_range(40, 120);
							gap_left   <= 0;
						end else begin
							burst_left <= $urandom_range(1, 20);
							gap_left   <= $urandom_range(1, 8);
						end
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-offs, so that the engine fills up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && accepted_count >= (holds_done + 1) * HOLD_SPACING) begin
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: stalls the result channel and checks every transfer
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		console_rsp_t want;
		logic         stall_bit;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch($sformatf(
						"result transfer with none expected (start %h cursor %h data %h)",
						screen_start, cursor_cell, read_data));
				end else begin
					want = expected_rsps.pop_front();
					if (screen_start !== want.screen_start) begin
						report_mismatch($sformatf("screen_start got %h expected %h",
							screen_start, want.screen_start));
					end
					if (cursor_cell !== want.cursor_cell) begin
						report_mismatch($sformatf("cursor_cell got %h expected %h",
							cursor_cell, want.cursor_cell));
					end
					if (read_data !== want.read_data) begin
						report_mismatch($sformatf("read_data got %h expected %h",
							read_data, want.read_data));
					end
				end
			end
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_left <= $urandom_range(10, 200);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0: stall_bit = 1'b0;
				1: stall_bit = 1'($urandom_range(0, 1));
				2: stall_bit = ($urandom_range(0, 3) == 0);
				default: stall_bit = (stall_left % 3 == 0);
			endcase
			rsp_stall <= stall_bit || (hold_left != 0);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		blank_console();
		m_attr = tce_pkg::ATTR_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed bytes under the reset attribute
		add_write(8'h41, 1'b1);
		add_read(tce_pkg::CELL_W'(0));
		add_write(tce_pkg::CH_BS, 1'b1);
		add_read(tce_pkg::CELL_W'(0));
		add_write(tce_pkg::CH_BS, 1'b0);
		add_write(8'hFF, 1'b0);
		add_write(8'h80, 1'b0);
		add_write(8'h01, 1'b1);
		add_write(tce_pkg::CH_DEL, 1'b0);
		add_write(tce_pkg::CH_CR, 1'b1);
		add_write(tce_pkg::CH_DEL, 1'b0);
		add_read(tce_pkg::CELL_W'(0));
		add_write(tce_pkg::CH_LF, 1'b1);
		add_write(8'h5A, 1'b0);
		add_write(tce_pkg::CH_FF, 1'b1);
		add_write(tce_pkg::CH_NUL, 1'b0);
		add_write(tce_pkg::CH_BEL, 1'b0);
		add_write(tce_pkg::CH_HT, 1'b0);
		add_write(tce_pkg::CH_VT, 1'b1);
		add_read(tce_pkg::CELL_W'(81));
		add_read(tce_pkg::CELL_W'(tce_pkg::MEMORY_CELLS - 1));
		add_cmd(CMD_UNUSED, 8'hFF, 1'b1, tce_pkg::CELL_W'(tce_pkg::MEMORY_CELLS - 1));
		add_cmd(tce_pkg::CMD_CLEAR, 8'h00, 1'b0, '0);
		add_read(tce_pkg::CELL_W'(1));
		wait_idle();

		write_text_attribute(8'hFF);
		queue_random_traffic(PHASE_ITEMS);
		wait_idle();
		write_text_attribute(8'h00);
		queue_random_traffic(PHASE_ITEMS);
		wait_idle();
		write_text_attribute(8'($urandom));
		queue_random_traffic(PHASE_ITEMS);
		wait_idle();
		write_text_attribute(8'($urandom));
		queue_random_traffic(PHASE_ITEMS);
		wait_idle();
		repeat (50) @(negedge clk);

		if (error_count == 0 && expected_rsps.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/tce_pkg.sv
rtl/core/tce_ctrl.sv
rtl/core/tce_datapath.sv
rtl/core/text_console_engine.sv
test/tb.sv
